// ----- src/u16alu_pkg.sv -----
// Shared types and constants of the 16-bit checked ALU.
// Used by the front-end, the divider step, the top level and the checker; depends on nothing.
package u16alu_pkg;

  localparam int DataW            = 16;
  localparam int NumStages        = 4;
  localparam int DivStepsPerStage = DataW / NumStages;
  localparam logic [DataW-1:0] MaxShift = DataW'(15);

  typedef enum logic [3:0] {
    OpAddChk  = 4'd0,
    OpAddWrap = 4'd1,
    OpSubChk  = 4'd2,
    OpSubWrap = 4'd3,
    OpMulChk  = 4'd4,
    OpMulWrap = 4'd5,
    OpDiv     = 4'd6,
    OpRem     = 4'd7,
    OpEq      = 4'd8,
    OpGt      = 4'd9,
    OpAnd     = 4'd10,
    OpOr      = 4'd11,
    OpXor     = 4'd12,
    OpNot     = 4'd13,
    OpShl     = 4'd14,
    OpShr     = 4'd15
  } op_e;

  // One pipeline slot: divider state travels with the precomputed result
  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] divisor;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] val;
    logic             fault;
  } pipe_t;

endpackage

// ----- src/u16alu_front.sv -----
// Combinational operations of the ALU: add, sub, mul, compare, logic, shift.
// Depends on u16alu_pkg; division is resolved later in the pipeline.
module u16alu_front import u16alu_pkg::*; (
  input  op_e              op_i,
  input  logic [DataW-1:0] operand_a_i,
  input  logic [DataW-1:0] operand_b_i,
  output logic [DataW-1:0] val_o,
  output logic             fault_o
);

  logic [DataW:0]     sum;
  logic [DataW:0]     diff;
  logic [2*DataW-1:0] prod;
  logic               big_shift;

  assign sum       = {1'b0, operand_a_i} + {1'b0, operand_b_i};
  assign diff      = {1'b0, operand_a_i} - {1'b0, operand_b_i};
  assign prod      = operand_a_i * operand_b_i;
  assign big_shift = operand_b_i > MaxShift;

  always_comb begin
    val_o   = '0;
    fault_o = 1'b0;
    case (op_i)
      OpAddChk: begin
        val_o   = sum[DataW-1:0];
        fault_o = sum[DataW];
      end
      OpAddWrap: val_o = sum[DataW-1:0];
      OpSubChk: begin
        val_o   = diff[DataW-1:0];
        fault_o = diff[DataW];
      end
      OpSubWrap: val_o = diff[DataW-1:0];
      OpMulChk: begin
        val_o   = prod[DataW-1:0];
        fault_o = |prod[2*DataW-1:DataW];
      end
      OpMulWrap: val_o = prod[DataW-1:0];
      OpEq:      val_o = DataW'(operand_a_i == operand_b_i);
      OpGt:      val_o = DataW'(operand_a_i > operand_b_i);
      OpAnd:     val_o = operand_a_i & operand_b_i;
      OpOr:      val_o = operand_a_i | operand_b_i;
      OpXor:     val_o = operand_a_i ^ operand_b_i;
      OpNot:     val_o = ~operand_a_i;
      OpShl:     val_o = big_shift ? '0 : operand_a_i << operand_b_i[3:0];
      OpShr:     val_o = big_shift ? '0 : operand_a_i >> operand_b_i[3:0];
      default: begin
        // div and rem are finished at the last stage
        val_o   = '0;
        fault_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/u16alu_div_step.sv -----
// Restoring divider slice: DivStepsPerStage (4) quotient bits per pipeline stage.
// Depends on u16alu_pkg for the data width and bits per stage.
module u16alu_div_step import u16alu_pkg::*; (
  input  logic [DataW-1:0] rem_i,
  input  logic [DataW-1:0] quo_i,
  input  logic [DataW-1:0] divisor_i,
  output logic [DataW-1:0] rem_o,
  output logic [DataW-1:0] quo_o
);

  always_comb begin
    logic [DataW:0]   trial;
    logic [DataW-1:0] r;
    logic [DataW-1:0] q;
    r = rem_i;
    q = quo_i;
    for (int i = 0; i < DivStepsPerStage; i++) begin
      // shift the next dividend bit into the partial remainder
      trial = {r, q[DataW-1]};
      q     = {q[DataW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
        q[0]  = 1'b1;
      end
      r = trial[DataW-1:0];
    end
    rem_o = r;
    quo_o = q;
  end

endmodule

// ----- src/uint16_checked_alu.sv -----
// 16-bit unsigned ALU with overflow, underflow and zero-divisor checks. One request is
// accepted per cycle while s_axis_tready is high; each result passes through every
// stage register. The divider resolves 4 quotient bits in each of 4 stages, and all
// other operations ride along the same stages so results leave in request order.
// Each stage holds its slot until the next one frees, so a stalled output does not
// block intake until all 4 stages are full.
module uint16_checked_alu import u16alu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] operand_a, [31:16] operand_b
  input  logic [3:0]  s_axis_tuser,   // [3:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] value
  output logic [0:0]  m_axis_tuser    // [0] fault
);

  localparam int Last = NumStages - 1;

  pipe_t                entry;
  logic [DataW-1:0]     front_val;
  logic                 front_fault;
  pipe_t                stage_q [NumStages];
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   rdy;

  u16alu_front u_front (
    .op_i        (op_e'(s_axis_tuser)),
    .operand_a_i (s_axis_tdata[15:0]),
    .operand_b_i (s_axis_tdata[31:16]),
    .val_o       (front_val),
    .fault_o     (front_fault)
  );

  always_comb begin
    entry.op      = op_e'(s_axis_tuser);
    entry.divisor = s_axis_tdata[31:16];
    entry.rem     = '0;
    entry.quo     = s_axis_tdata[15:0];
    entry.val     = front_val;
    entry.fault   = front_fault;
  end

  assign rdy[NumStages] = m_axis_tready;
  assign s_axis_tready  = rdy[0];

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    pipe_t            src;
    pipe_t            stage_d;
    logic             src_valid;
    logic [DataW-1:0] step_rem;
    logic [DataW-1:0] step_quo;

    if (k == 0) begin : g_first
      assign src       = entry;
      assign src_valid = s_axis_tvalid;
    end else begin : g_next
      assign src       = stage_q[k-1];
      assign src_valid = valid_q[k-1];
    end

    // a stage may load when it is empty or its content moves on
    assign rdy[k] = ~valid_q[k] | rdy[k+1];

    u16alu_div_step u_div (
      .rem_i     (src.rem),
      .quo_i     (src.quo),
      .divisor_i (src.divisor),
      .rem_o     (step_rem),
      .quo_o     (step_quo)
    );

    always_comb begin
      stage_d     = src;
      stage_d.rem = step_rem;
      stage_d.quo = step_quo;
      if (k == Last && (src.op == OpDiv || src.op == OpRem)) begin
        if (src.divisor == '0) begin
          stage_d.val   = '0;
          stage_d.fault = 1'b1;
        end else begin
          stage_d.val   = (src.op == OpDiv) ? step_quo : step_rem;
          stage_d.fault = 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_valid) begin
        stage_q[k] <= stage_d;
      end
    end
  end

  assign m_axis_tvalid   = valid_q[Last];
  assign m_axis_tdata    = stage_q[Last].val;
  assign m_axis_tuser[0] = stage_q[Last].fault;

endmodule

// ----- src/u16alu_checker.sv -----
// Port-level checks for the 16-bit checked ALU, attached to the top level by bind.
// Depends on u16alu_pkg for the pipeline depth.
module u16alu_checker import u16alu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,   // [15:0] value
  input logic [0:0]  m_axis_tuser    // [0] fault
);

  logic [2:0] occ_q;
  logic [2:0] occ_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;
  assign occ_d   = occ_q + 3'(in_acc) - 3'(out_acc);

  // track requests in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("intake stalled while output drains");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> occ_q == 3'(NumStages))
    else $error("intake stalled with free stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> occ_q != 3'd0)
    else $error("result without a pending request");

endmodule

bind uint16_checked_alu u16alu_checker u_u16alu_checker (.*);
